@@ hw/rtl/mtpc_pkg.sv @@
// Package for the multi-trial phase folding block.
// Holds command codes, widths, and the command and status structs; no dependencies.
package mtpc_pkg;

  localparam logic CmdFill = 1'b0;
  localparam logic CmdStat = 1'b1;

  localparam int unsigned StatBits = 56;
  localparam int unsigned FracBits = 16;
  localparam int unsigned AccBits  = 96;

  typedef enum logic [3:0] {
    OpNone,
    OpClear,
    OpFillRead,
    OpFillWrite,
    OpStatInit,
    OpStatRead,
    OpStatAcc,
    OpStatScale,
    OpDivInit,
    OpDivStep
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic div_done;
    logic early_out;
  } dp_sts_t;

endpackage

@@ hw/rtl/mtpc_ctrl.sv @@
// Controller for the multi-trial phase folding block.
// Sequences clearing, fill read-modify-write and statistic steps; uses mtpc_pkg.
module mtpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic               res_free_i,
  input  mtpc_pkg::dp_sts_t  sts_i,
  output mtpc_pkg::dp_cmd_t  dp_cmd_o,
  output logic               res_load_o
);

  typedef enum logic [3:0] {
    StClear, StIdle, StFillWr, StStatRd, StStatAcc, StScale, StDivInit, StDiv, StDone
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    dp_cmd_o.op   = mtpc_pkg::OpNone;
    dp_cmd_o.last = 1'b0;
    res_load_o    = 1'b0;
    unique case (state_q)
      StClear:   dp_cmd_o.op = mtpc_pkg::OpClear;
      StIdle: begin
        if (in_valid_i) begin
          dp_cmd_o.op = (cmd_i == mtpc_pkg::CmdFill) ? mtpc_pkg::OpFillRead
                                                     : mtpc_pkg::OpStatInit;
        end
      end
      StFillWr:  dp_cmd_o.op = mtpc_pkg::OpFillWrite;
      StStatRd:  dp_cmd_o.op = mtpc_pkg::OpStatRead;
      StStatAcc: begin
        dp_cmd_o.op   = mtpc_pkg::OpStatAcc;
        dp_cmd_o.last = sts_i.scan_done;
      end
      StScale:   dp_cmd_o.op = mtpc_pkg::OpStatScale;
      StDivInit: dp_cmd_o.op = mtpc_pkg::OpDivInit;
      StDiv:     dp_cmd_o.op = mtpc_pkg::OpDivStep;
      StDone:    res_load_o  = res_free_i;
      default:   dp_cmd_o.op = mtpc_pkg::OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      unique case (state_q)
        StClear:   if (sts_i.clear_done) state_q <= StIdle;
        StIdle: begin
          if (in_valid_i) begin
            state_q <= (cmd_i == mtpc_pkg::CmdFill) ? StFillWr : StStatRd;
          end
        end
        StFillWr:  state_q <= StIdle;
        StStatRd: begin
          state_q <= sts_i.early_out ? StDone : StStatAcc;
        end
        StStatAcc: state_q <= sts_i.scan_done ? StScale : StStatAcc;
        StScale:   state_q <= StDivInit;
        StDivInit: state_q <= StDiv;
        StDiv:     if (sts_i.div_done) state_q <= StDone;
        StDone:    if (res_free_i) state_q <= StIdle;
        default:   state_q <= StIdle;
      endcase
    end
  end

endmodule

@@ hw/rtl/mtpc_dp.sv @@
// Datapath for the multi-trial phase folding block: bin memory, per-trial
// totals, sum of squares and a restoring divider. Uses mtpc_pkg.
module mtpc_dp #(
  parameter int unsigned TRIAL_COUNT = 64,
  parameter int unsigned MAX_BINS    = 32,
  parameter int unsigned COUNT_BITS  = 24,
  parameter int unsigned PHASE_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtpc_pkg::dp_cmd_t dp_cmd_i,
  input  logic [5:0]        num_bins_q_i,
  input  logic [5:0]        trial_index_i,
  input  logic [31:0]       phase_i,
  output mtpc_pkg::dp_sts_t sts_o,
  output logic [mtpc_pkg::StatBits-1:0] stat_o,
  output logic              no_events_o,
  output logic              sat_o
);

  localparam int unsigned TrialW = (TRIAL_COUNT > 1) ? $clog2(TRIAL_COUNT) : 1;
  localparam int unsigned BinW   = $clog2(MAX_BINS);
  localparam int unsigned NbW    = BinW + 1;
  localparam int unsigned Depth  = TRIAL_COUNT * MAX_BINS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned AccW   = mtpc_pkg::AccBits;
  localparam int unsigned DivW   = mtpc_pkg::AccBits;
  localparam int unsigned CntW   = $clog2(DivW + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [COUNT_BITS-1:0] mem_q [Depth];
  logic [COUNT_BITS-1:0] rd_q;
  logic [COUNT_BITS-1:0] tot_q [TRIAL_COUNT];
  logic                  sat_q [TRIAL_COUNT];

  logic [AddrW:0]        clr_q;
  logic [TrialW-1:0]     trial_q;
  logic                  tvalid_q;
  logic [BinW-1:0]       bin_q;
  logic [NbW-1:0]        nb_q;
  logic [NbW-1:0]        j_q;
  logic [AccW-1:0]       acc_q;
  logic [COUNT_BITS-1:0] n_q;
  logic [AccW-1:0]       rem_q;
  logic [DivW-1:0]       quo_q;
  logic [AccW-1:0]       num_q;
  logic [CntW-1:0]       cnt_q;
  logic                  neg_q;

  logic [NbW-1:0]        nb_use;
  logic [TrialW-1:0]     t_in;
  logic                  t_ok;
  logic [PHASE_BITS-1:0] ph;
  logic [PHASE_BITS+NbW-1:0] prod;
  logic [BinW-1:0]       bin_in;
  logic [AddrW-1:0]      rd_addr;
  logic [AccW-1:0]       sq;
  logic [AccW-1:0]       scaled;
  logic [AccW-1:0]       nsq;
  logic [AccW:0]         trial_rem;

  always_comb begin
    if (num_bins_q_i < 6'd2) nb_use = NbW'(2);
    else if (32'(num_bins_q_i) > MAX_BINS) nb_use = NbW'(MAX_BINS);
    else nb_use = NbW'(num_bins_q_i);
  end

  assign t_ok   = 32'(trial_index_i) < TRIAL_COUNT;
  assign t_in   = TrialW'(trial_index_i);
  assign ph     = phase_i[31 -: PHASE_BITS];
  assign prod   = (PHASE_BITS+NbW)'(ph) * (PHASE_BITS+NbW)'(nb_use);
  assign bin_in = BinW'(prod >> PHASE_BITS);

  always_comb begin
    rd_addr = '0;
    unique case (dp_cmd_i.op)
      mtpc_pkg::OpFillRead: rd_addr = AddrW'(t_in) * AddrW'(MAX_BINS) + AddrW'(bin_in);
      default: rd_addr = AddrW'(trial_q) * AddrW'(MAX_BINS) + AddrW'(j_q[BinW-1:0]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == mtpc_pkg::OpClear) begin
      mem_q[clr_q[AddrW-1:0]] <= '0;
    end else if (dp_cmd_i.op == mtpc_pkg::OpFillWrite && tvalid_q && rd_q != CountMax) begin
      mem_q[AddrW'(trial_q) * AddrW'(MAX_BINS) + AddrW'(bin_q)] <= rd_q + 1'b1;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == mtpc_pkg::OpClear) begin
      if (clr_q < (AddrW+1)'(TRIAL_COUNT)) begin
        tot_q[TrialW'(clr_q)] <= '0;
        sat_q[TrialW'(clr_q)] <= 1'b0;
      end
    end else if (dp_cmd_i.op == mtpc_pkg::OpFillWrite && tvalid_q) begin
      if (rd_q == CountMax || n_q == CountMax) sat_q[trial_q] <= 1'b1;
      if (n_q != CountMax) tot_q[trial_q] <= n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      if (dp_cmd_i.op == mtpc_pkg::OpClear) clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.clear_done = (clr_q == (AddrW+1)'(Depth - 1));
  assign sts_o.scan_done  = (j_q == nb_q);
  assign sts_o.div_done   = (cnt_q == CntW'(1));
  assign sts_o.early_out  = !tvalid_q || n_q == '0;

  assign sq     = AccW'(rd_q) * AccW'(rd_q);
  assign scaled = (acc_q * AccW'(nb_q)) << mtpc_pkg::FracBits;
  assign nsq    = (AccW'(n_q) * AccW'(n_q)) << mtpc_pkg::FracBits;
  assign trial_rem = {rem_q, num_q[AccW-1]} - (AccW+1)'(n_q);

  always_ff @(posedge clk_i) begin
    unique case (dp_cmd_i.op)
      mtpc_pkg::OpFillRead, mtpc_pkg::OpStatInit: begin
        trial_q  <= t_in;
        tvalid_q <= t_ok;
        bin_q    <= bin_in;
        nb_q     <= nb_use;
        j_q      <= '0;
        acc_q    <= '0;
        n_q      <= t_ok ? tot_q[t_in] : '0;
        sat_o    <= t_ok ? sat_q[t_in] : 1'b0;
      end
      mtpc_pkg::OpStatRead: begin
        no_events_o <= sts_o.early_out;
        stat_o      <= '0;
        if (!dp_cmd_i.last) j_q <= j_q + 1'b1;
      end
      mtpc_pkg::OpStatAcc: begin
        acc_q <= acc_q + sq;
        j_q   <= j_q + 1'b1;
      end
      mtpc_pkg::OpStatScale: begin
        neg_q <= scaled < nsq;
        num_q <= scaled - nsq;
      end
      mtpc_pkg::OpDivInit: begin
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CntW'(AccW);
      end
      mtpc_pkg::OpDivStep: begin
        if (!trial_rem[AccW]) begin
          rem_q <= trial_rem[AccW-1:0];
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[AccW-2:0], num_q[AccW-1]};
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
        num_q <= num_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (sts_o.div_done) begin
          if (neg_q) stat_o <= '0;
          else if (|quo_q[DivW-2:mtpc_pkg::StatBits-1]) stat_o <= '1;
          else stat_o <= {quo_q[mtpc_pkg::StatBits-2:0], !trial_rem[AccW]};
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/multi_trial_phase_chi2_folding_top.sv @@
// Top level of the multi-trial phase folding block with Pearson statistic.
// Joins mtpc_ctrl and mtpc_dp; uses mtpc_pkg.
//
// Input channel in_valid_i/in_ready_o carries cmd_i, trial_index_i, phase_i.
// A fill item (cmd 0) bins the phase and increments that bin and the trial's
// event count with a memory read, then a write, and gives no result.
// A stat item (cmd 1) gives one result on out_valid_o/out_ready_i:
// stat_value_o, no_events_o, count_saturated_o. It scans num_bins bins, one
// memory read a cycle, then runs a restoring divider one quotient bit a
// cycle; an empty trial or an out-of-range trial index skips both.
// The result waits in an output register; the block takes new items while
// it waits, and a second stat stalls until the first is taken.
// After reset the bin memory and the per-trial totals are cleared, one entry
// a cycle, while in_ready_o stays low.
// num_bins is written through cfg_we_i/cfg_wdata_i, reset value 32.
module multi_trial_phase_chi2_folding_top #(
  parameter int unsigned TRIAL_COUNT = 64,
  parameter int unsigned MAX_BINS    = 32,
  parameter int unsigned COUNT_BITS  = 24,
  parameter int unsigned PHASE_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [5:0]  trial_index_i,
  input  logic [31:0] phase_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [55:0] stat_value_o,
  output logic        no_events_o,
  output logic        count_saturated_o
);

  logic [5:0]        num_bins_q;
  mtpc_pkg::dp_cmd_t dp_cmd;
  mtpc_pkg::dp_sts_t dp_sts;
  logic              res_load;
  logic [55:0]       stat_w;
  logic              noev_w;
  logic              sat_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q  <= 6'd32;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) num_bins_q <= cfg_wdata_i;
      if (res_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      stat_value_o      <= stat_w;
      no_events_o       <= noev_w;
      count_saturated_o <= sat_w;
    end
  end

  mtpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .res_free_i (!out_valid_o || out_ready_i),
    .sts_i      (dp_sts),
    .dp_cmd_o   (dp_cmd),
    .res_load_o (res_load)
  );

  mtpc_dp #(
    .TRIAL_COUNT (TRIAL_COUNT),
    .MAX_BINS    (MAX_BINS),
    .COUNT_BITS  (COUNT_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_cmd_i      (dp_cmd),
    .num_bins_q_i  (num_bins_q),
    .trial_index_i (trial_index_i),
    .phase_i       (phase_i),
    .sts_o         (dp_sts),
    .stat_o        (stat_w),
    .no_events_o   (noev_w),
    .sat_o         (sat_w)
  );

endmodule

@@ tb/tb_multi_trial_phase_chi2_folding_top.sv @@
// Testbench for multi_trial_phase_chi2_folding_top: random and directed fill/stat items
// checked against a scoreboard that keeps its own histogram bank; uses mtpc_pkg.
`timescale 1ns / 1ps

class chi2_scoreboard;
  typedef struct {
    logic [55:0] stat_value;
    logic        no_events;
    logic        count_saturated;
  } chi2_result_t;

  logic [23:0]  bin_cnt[64][32];
  logic [23:0]  event_cnt[64];
  bit           sat_mark[64];
  logic [5:0]   bins_reg;
  chi2_result_t due_q[$];
  int           errors;
  int           fills;
  int           stats;
  int           cfg_writes;

  function new();
    for (int t = 0; t < 64; t++) begin
      for (int b = 0; b < 32; b++) bin_cnt[t][b] = '0;
      event_cnt[t] = '0;
      sat_mark[t] = 0;
    end
    bins_reg = 6'd32;
    errors = 0;
    fills = 0;
    stats = 0;
    cfg_writes = 0;
  endfunction

  function void note_cfg(logic [5:0] v);
    bins_reg = v;
    cfg_writes++;
  endfunction

  function int bins_used();
    if (bins_reg < 2) return 2;
    if (bins_reg > 32) return 32;
    return bins_reg;
  endfunction

  function logic [55:0] pearson(int t, int nb);
    logic [127:0] acc;
    logic [127:0] sub;
    logic [127:0] q;
    logic [127:0] n;
    acc = '0;
    n = event_cnt[t];
    for (int b = 0; b < nb; b++) acc += bin_cnt[t][b] * bin_cnt[t][b];
    acc = (acc * nb) << mtpc_pkg::FracBits;
    sub = (n * n) << mtpc_pkg::FracBits;
    if (acc < sub) return '0;
    q = (acc - sub) / n;
    if (q > 128'h00FF_FFFF_FFFF_FFFF) return 56'hFF_FFFF_FFFF_FFFF;
    return q[55:0];
  endfunction

  function void note_input(logic cmd, logic [5:0] t, logic [31:0] phase);
    chi2_result_t r;
    int nb;
    logic [63:0] bin;
    nb = bins_used();
    if (cmd == mtpc_pkg::CmdFill) begin
      fills++;
      bin = ({32'd0, phase} * nb) >> 32;
      if (bin_cnt[t][bin] == 24'hFF_FFFF) sat_mark[t] = 1;
      else bin_cnt[t][bin]++;
      if (event_cnt[t] == 24'hFF_FFFF) sat_mark[t] = 1;
      else event_cnt[t]++;
      return;
    end
    stats++;
    r.count_saturated = sat_mark[t];
    if (event_cnt[t] == 0) begin
      r.stat_value = '0;
      r.no_events = 1;
    end else begin
      r.stat_value = pearson(t, nb);
      r.no_events = 0;
    end
    due_q.push_back(r);
  endfunction

  function void check_result(logic [55:0] v, logic ne, logic cs);
    chi2_result_t r;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: stat %h no_events %b sat %b", v, ne, cs);
      return;
    end
    r = due_q.pop_front();
    if (v !== r.stat_value || ne !== r.no_events || cs !== r.count_saturated) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: stat exp %h got %h, no_events exp %b got %b, sat exp %b got %b",
                 r.stat_value, v, r.no_events, ne, r.count_saturated, cs);
    end
  endfunction
endclass

module tb_multi_trial_phase_chi2_folding_top;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic        cmd_i = mtpc_pkg::CmdFill;
  logic [5:0]  trial_index_i = '0;
  logic [31:0] phase_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [55:0] stat_value_o;
  logic        no_events_o;
  logic        count_saturated_o;

  chi2_scoreboard sb = new();
  bit quiet = 0;
  bit long_hold = 0;

  multi_trial_phase_chi2_folding_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .cmd_i, .trial_index_i, .phase_i, .out_valid_o, .out_ready_i,
    .stat_value_o, .no_events_o, .count_saturated_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.note_cfg(cfg_wdata_i);
      if (in_valid_i && in_ready_o) sb.note_input(cmd_i, trial_index_i, phase_i);
      if (out_valid_o && out_ready_i) sb.check_result(stat_value_o, no_events_o, count_saturated_o);
    end
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ready_i <= 0;
        repeat (600) @(posedge clk_i);
        long_hold = 0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1;
        n = quiet ? 1 : $urandom_range(1, 15);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(logic cmd, logic [5:0] t, logic [31:0] phase);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    cmd_i <= cmd;
    trial_index_i <= t;
    phase_i <= phase;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_and_write(logic [5:0] v);
    in_valid_i <= 0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_item();
    logic [5:0] t;
    t = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
    if ($urandom_range(0, 8) == 0) send_item(mtpc_pkg::CmdStat, t, $urandom);
    else send_item(mtpc_pkg::CmdFill, t, $urandom);
  endtask

  initial begin
    logic [5:0] settings[10];
    settings = '{6'd32, 6'd2, 6'd0, 6'd1, 6'd63, 6'd33, 6'd7, 6'd17, 6'd5, 6'd32};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    cfg_we_i <= 1;
    cfg_wdata_i <= settings[0];
    @(posedge clk_i);
    cfg_we_i <= 0;
    send_item(mtpc_pkg::CmdStat, 6'd5, 32'hFFFF_FFFF);
    send_item(mtpc_pkg::CmdStat, 6'd63, '0);
    send_item(mtpc_pkg::CmdFill, 6'd0, 32'h0000_0000);
    send_item(mtpc_pkg::CmdFill, 6'd0, 32'hFFFF_FFFF);
    send_item(mtpc_pkg::CmdFill, 6'd0, 32'h8000_0000);
    send_item(mtpc_pkg::CmdFill, 6'd0, 32'h7FFF_FFFF);
    send_item(mtpc_pkg::CmdStat, 6'd0, '0);
    send_item(mtpc_pkg::CmdFill, 6'd63, 32'hFFFF_FFFF);
    send_item(mtpc_pkg::CmdStat, 6'd63, '0);
    for (int i = 0; i < 6; i++) send_item(mtpc_pkg::CmdFill, 6'd1, 32'hC000_0000);
    send_item(mtpc_pkg::CmdStat, 6'd1, '0);

    for (int p = 1; p < 10; p++) begin
      drain_and_write(p == 9 ? 6'($urandom_range(0, 63)) : settings[p]);
      send_item(mtpc_pkg::CmdStat, 6'd1, '0);
      send_item(mtpc_pkg::CmdStat, 6'd0, '0);
      if (p == 3) begin
        long_hold = 1;
        for (int i = 0; i < 8; i++) send_item(mtpc_pkg::CmdStat, 6'(i), $urandom);
      end
      if (p == 9) quiet = 1;
      for (int i = 0; i < 212; i++) random_item();
      if (p == 5) begin
        in_valid_i <= 0;
        while (sb.due_q.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
    end

    in_valid_i <= 0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d fills and %0d stat queries over %0d bin settings",
             sb.fills, sb.stats, sb.cfg_writes);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/mtpc_pkg.sv
hw/rtl/mtpc_ctrl.sv
hw/rtl/mtpc_dp.sv
hw/rtl/multi_trial_phase_chi2_folding_top.sv
tb/tb_multi_trial_phase_chi2_folding_top.sv
